FILE: src/tkh_pkg.sv
// Package for the top-K score store: sequencer states and field widths.
// Used by top_k_score_heap; no dependencies.
`default_nettype none
package tkh_pkg;

    localparam int SCORE_W = 31;
    localparam int DOC_W   = 32;
    localparam int THR_W   = 32;
    localparam int KEY_W   = SCORE_W + DOC_W;
    localparam int IN_W    = 64;
    localparam int OUT_W   = THR_W + 1 + SCORE_W + DOC_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_WUPD,
        S_INS_OUT,
        S_DSCAN,
        S_DEMIT
    } t_state;

endpackage
`default_nettype wire

FILE: src/tkh_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none
module tkh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

FILE: src/top_k_score_heap.sv
// Top level of the top-K score store: sequencer, key comparators, output register.
// Depends on tkh_pkg and tkh_ram.
//
// Usage. Items arrive on the s_ channel: s_tuser is the mode (0 insert, 1 drain),
// s_tdata holds score and doc id. Results leave on the m_ channel, one transaction
// per insert and one per drained entry (one for a drain of an empty store); m_tlast
// marks the final result of an item, m_tuser flags a drained entry.
// start_threshold is to be written through the cfg channel only while the block is
// idle; the block does not enforce this. Throughput: one item at a time; s_tready is
// high only in the idle state. An insert into a store that is not full writes its key
// and then loads its result. An insert that leaves the store full first makes one pass
// over the entry RAM through its single read port to find the weakest entry, which may
// raise the threshold and sets the slot the next insert overwrites. A drain of n
// entries makes one RAM pass per distinct entry, best entry first.
// Reset clears the fill count, the threshold and start_threshold to zero; the
// entry RAM is not cleared, only entries below the fill count are read.
// When the receiver stalls, a finished result waits in the output register and
// the sequencer holds before loading the next; it takes a new item once the last is loaded.
`default_nettype none
module top_k_score_heap #(
    parameter int TOP_K = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // config: start_threshold
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [31:0] i_cfg_data,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // score[30:0], doc_id[62:31], zero [63]
    input  wire logic [0:0]  s_tuser,   // mode[0]
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [95:0]      m_tdata,   // threshold[31:0], full_res[32],
                                        // entry_score[63:33], entry_doc[95:64]
    output logic [0:0]       m_tuser,   // entry_valid[0]
    output logic             m_tlast
);

    import tkh_pkg::*;

    localparam int CW = $clog2(TOP_K + 1);
    localparam int IW = (TOP_K > 1) ? $clog2(TOP_K) : 1;
    localparam logic [CW-1:0] K_CNT = CW'(TOP_K);

    // control registers
    t_state            r_state, n_state;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [THR_W-1:0]  r_thr, n_thr;
    logic [THR_W-1:0]  r_start, n_start;
    logic [CW-1:0]     r_addr, n_addr;
    logic              r_rd_vld, n_rd_vld;
    logic              r_found, n_found;
    logic              r_first, n_first;
    logic              r_o_valid, n_o_valid;
    // payload registers
    logic [IW-1:0]     r_rd_idx, n_rd_idx;
    logic [IW-1:0]     r_weak_idx, n_weak_idx;
    logic [KEY_W-1:0]  r_best_key, n_best_key;
    logic [IW-1:0]     r_best_idx, n_best_idx;
    logic [KEY_W-1:0]  r_prev_key, n_prev_key;
    logic [CW-1:0]     r_mult, n_mult;
    logic [CW-1:0]     r_emit, n_emit;
    logic [OUT_W-1:0]  r_o_data, n_o_data;
    logic              r_o_ev, n_o_ev;
    logic              r_o_last, n_o_last;

    // RAM port
    logic              ram_we;
    logic [IW-1:0]     ram_waddr;
    logic [KEY_W-1:0]  ram_wdata;
    logic [KEY_W-1:0]  ram_rdata;

    // key = {score, ~doc}: a larger key ranks better
    logic [KEY_W-1:0]  in_key;
    logic              in_acc;
    logic              out_free;
    logic              issue;
    logic              last_data;
    logic              key_lt_best;
    logic              key_gt_best;
    logic              key_eq_best;
    logic              key_lt_prev;
    logic              thr_rise;
    logic [SCORE_W-1:0] weak_score;

    assign in_key   = {s_tdata[SCORE_W-1:0], ~s_tdata[SCORE_W +: DOC_W]};
    assign s_tready = (r_state == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !r_o_valid || m_tready;
    assign issue    = ((r_state == S_SCAN) || (r_state == S_DSCAN)) && (r_addr < r_cnt);
    assign last_data = r_rd_vld && ((CW'(r_rd_idx) + 1'b1) == r_cnt);

    assign key_lt_best = ram_rdata < r_best_key;
    assign key_gt_best = ram_rdata > r_best_key;
    assign key_eq_best = ram_rdata == r_best_key;
    assign key_lt_prev = ram_rdata < r_prev_key;

    assign weak_score = r_best_key[KEY_W-1 -: SCORE_W];
    assign thr_rise   = $signed(r_thr) < $signed({1'b0, weak_score});

    tkh_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TOP_K),
        .AW    (IW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_addr[IW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_thr      = r_thr;
        n_start    = r_start;
        n_addr     = r_addr;
        n_rd_vld   = issue;
        n_rd_idx   = r_addr[IW-1:0];
        n_found    = r_found;
        n_first    = r_first;
        n_weak_idx = r_weak_idx;
        n_best_key = r_best_key;
        n_best_idx = r_best_idx;
        n_prev_key = r_prev_key;
        n_mult     = r_mult;
        n_emit     = r_emit;
        n_o_valid  = r_o_valid && !m_tready;
        n_o_data   = r_o_data;
        n_o_ev     = r_o_ev;
        n_o_last   = r_o_last;
        ram_we     = 1'b0;
        ram_waddr  = r_cnt[IW-1:0];
        ram_wdata  = in_key;

        if (i_cfg_valid) begin
            n_start = i_cfg_data;
        end

        if (issue) begin
            n_addr = r_addr + 1'b1;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_addr = '0;
                    if (s_tuser[0] == 1'b0) begin
                        ram_we = 1'b1;
                        if (r_cnt == K_CNT) begin
                            ram_waddr = r_weak_idx;
                            n_state   = S_SCAN;
                        end else begin
                            n_cnt   = r_cnt + 1'b1;
                            n_state = ((r_cnt + 1'b1) == K_CNT) ? S_SCAN : S_INS_OUT;
                        end
                    end else if (r_cnt == '0) begin
                        n_thr   = r_start;
                        n_state = S_INS_OUT;
                    end else begin
                        n_first = 1'b1;
                        n_found = 1'b0;
                        n_emit  = '0;
                        n_state = S_DSCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_rd_vld && ((r_rd_idx == '0) || key_lt_best)) begin
                    n_best_key = ram_rdata;
                    n_best_idx = r_rd_idx;
                end
                if (last_data) begin
                    n_state = S_WUPD;
                end
            end
            S_WUPD: begin
                n_weak_idx = r_best_idx;
                if (thr_rise) begin
                    n_thr = {1'b0, weak_score};
                end
                n_state = S_INS_OUT;
            end
            S_INS_OUT: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_data  = {{DOC_W{1'b0}}, {SCORE_W{1'b0}}, (r_cnt == K_CNT), r_thr};
                    n_o_ev    = 1'b0;
                    n_o_last  = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            S_DSCAN: begin
                if (r_rd_vld && (r_first || key_lt_prev)) begin
                    if (!r_found || key_gt_best) begin
                        n_best_key = ram_rdata;
                        n_mult     = CW'(1);
                        n_found    = 1'b1;
                    end else if (key_eq_best) begin
                        n_mult = r_mult + 1'b1;
                    end
                end
                if (last_data) begin
                    n_state = S_DEMIT;
                end
            end
            S_DEMIT: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_data  = {~r_best_key[DOC_W-1:0], r_best_key[KEY_W-1 -: SCORE_W],
                                 1'b0, r_start};
                    n_o_ev    = 1'b1;
                    n_o_last  = (r_emit + 1'b1) == r_cnt;
                    n_emit    = r_emit + 1'b1;
                    n_mult    = r_mult - 1'b1;
                    if ((r_emit + 1'b1) == r_cnt) begin
                        n_cnt   = '0;
                        n_thr   = r_start;
                        n_state = S_IDLE;
                    end else if (r_mult == CW'(1)) begin
                        n_prev_key = r_best_key;
                        n_first    = 1'b0;
                        n_found    = 1'b0;
                        n_addr     = '0;
                        n_state    = S_DSCAN;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_thr     <= '0;
            r_start   <= '0;
            r_addr    <= '0;
            r_rd_vld  <= 1'b0;
            r_found   <= 1'b0;
            r_first   <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_thr     <= n_thr;
            r_start   <= n_start;
            r_addr    <= n_addr;
            r_rd_vld  <= n_rd_vld;
            r_found   <= n_found;
            r_first   <= n_first;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx   <= n_rd_idx;
        r_weak_idx <= n_weak_idx;
        r_best_key <= n_best_key;
        r_best_idx <= n_best_idx;
        r_prev_key <= n_prev_key;
        r_mult     <= n_mult;
        r_emit     <= n_emit;
        r_o_data   <= n_o_data;
        r_o_ev     <= n_o_ev;
        r_o_last   <= n_o_last;
    end

    assign o_cfg_ready = 1'b1;
    assign m_tvalid    = r_o_valid;
    assign m_tdata     = r_o_data;
    assign m_tuser     = r_o_ev;
    assign m_tlast     = r_o_last;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= K_CNT)
        else $error("fill count above TOP_K");

    a_drain_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DEMIT) && out_free && n_o_last) |=> (r_cnt == '0))
        else $error("store not emptied after final drained entry");

    a_rd_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> ((r_state == S_SCAN) || (r_state == S_DSCAN)))
        else $error("RAM read data outside a scan");

    a_emit_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEMIT) |-> (r_found && (r_mult != '0)))
        else $error("drain emit without a selected entry");

    a_thr_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WUPD) |=> ($signed(r_thr) >= $signed($past(r_thr))))
        else $error("threshold fell on insert");

endmodule
`default_nettype wire

FILE: verif/tb_top_k_score_heap.sv
// Testbench for top_k_score_heap: directed table, then random insert/drain sequences,
// each result checked against a top-K store predictor or, for typed rows, the table.
// Depends on tkh_pkg and the top_k_score_heap RTL.
`timescale 1ns / 100ps
module tb_top_k_score_heap;
    import tkh_pkg::*;

    localparam int K = 16;
    localparam int SETTLE = 40;
    localparam int NROWS = 25;
    localparam int PHASE_ITEMS = 58;

    typedef struct {
        logic [THR_W-1:0]   threshold;
        logic               full;
        logic [SCORE_W-1:0] entry_score;
        logic [DOC_W-1:0]   entry_doc;
        logic               entry_valid;
        logic               last;
    } t_heap_result;

    typedef struct packed {
        logic               mode;
        logic [SCORE_W-1:0] score;
        logic [DOC_W-1:0]   doc;
        logic               typed;
        logic [THR_W-1:0]   want_thr;
        logic               want_full;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // score[30:0], doc_id[62:31], zero [63]
    logic [0:0]  s_tuser;   // mode[0]
    logic        m_tvalid;
    logic        m_tready;
    logic [95:0] m_tdata;   // threshold[31:0], full_res[32], entry_score[63:33],
                            // entry_doc[95:64]
    logic [0:0]  m_tuser;   // entry_valid[0]
    logic        m_tlast;

    top_k_score_heap #(.TOP_K(K)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    // predictor state
    logic [SCORE_W-1:0] kept_sc [K];
    logic [DOC_W-1:0]   kept_id [K];
    int                 kept_n;
    logic [THR_W-1:0]   thr_now;
    logic [THR_W-1:0]   thr_start;

    t_heap_result due_results [$];
    int errors = 0;
    int cycle_no = 0;
    int results_seen = 0;
    int n_items;
    int n_drains;
    int n_cfg;

    t_row plan [NROWS] = '{
        '{1'b1, 31'h0,        32'h0,        1'b1, 32'h8000_0000, 1'b0},
        '{1'b0, 31'h7FFF_FFFF, 32'h0,       1'b1, 32'h8000_0000, 1'b0},
        '{1'b0, 31'h0,        32'hFFFF_FFFF, 1'b1, 32'h8000_0000, 1'b0},
        '{1'b0, 31'h0,        32'h0,        1'b1, 32'h8000_0000, 1'b0},
        '{1'b0, 31'h100,      32'd9,        1'b1, 32'h8000_0000, 1'b0},
        '{1'b0, 31'h100,      32'd3,        1'b1, 32'h8000_0000, 1'b0},
        '{1'b0, 31'h100,      32'd3,        1'b1, 32'h8000_0000, 1'b0},
        '{1'b0, 31'h100,      32'd12,       1'b1, 32'h8000_0000, 1'b0},
        '{1'b0, 31'h100,      32'd1,        1'b1, 32'h8000_0000, 1'b0},
        '{1'b0, 31'h100,      32'd7,        1'b1, 32'h8000_0000, 1'b0},
        '{1'b0, 31'h1_8000,   32'd20,       1'b1, 32'h8000_0000, 1'b0},
        '{1'b0, 31'h1_8000,   32'd21,       1'b1, 32'h8000_0000, 1'b0},
        '{1'b0, 31'h1_8000,   32'd22,       1'b1, 32'h8000_0000, 1'b0},
        '{1'b0, 31'h1_8000,   32'd23,       1'b1, 32'h8000_0000, 1'b0},
        '{1'b0, 31'h1_8000,   32'd24,       1'b1, 32'h8000_0000, 1'b0},
        '{1'b0, 31'h100,      32'd3,        1'b1, 32'h8000_0000, 1'b0},
        '{1'b0, 31'h0,        32'd2,        1'b1, 32'h0,         1'b1},
        '{1'b0, 31'h0,        32'd1,        1'b1, 32'h0,         1'b1},
        '{1'b0, 31'h0,        32'hFFFF_FFFF, 1'b1, 32'h0,        1'b1},
        '{1'b0, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0,       1'b0},
        '{1'b0, 31'h2000,     32'd4,        1'b0, 32'h0,         1'b0},
        '{1'b1, 31'h0,        32'h0,        1'b0, 32'h0,         1'b0},
        '{1'b1, 31'h0,        32'h0,        1'b1, 32'h8000_0000, 1'b0},
        '{1'b0, 31'h5555_5555, 32'hAAAA_AAAA, 1'b0, 32'h0,       1'b0},
        '{1'b0, 31'h2AAA_AAAA, 32'h5555_5555, 1'b0, 32'h0,       1'b0}
    };

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) cycle_no <= cycle_no + 1;

    function automatic bit quiet_window();
        return cycle_no >= 2000 && cycle_no < 5000;
    endfunction

    function automatic void queue_result(t_heap_result r);
        due_results.insert(due_results.size(), r);
    endfunction

    function automatic bit ranks_above(logic [SCORE_W-1:0] sa, logic [DOC_W-1:0] da,
                                       logic [SCORE_W-1:0] sb, logic [DOC_W-1:0] db);
        if (sa != sb)
            return sa > sb;
        return da < db;
    endfunction

    function automatic int weakest_slot();
        int w;
        w = 0;
        for (int i = 1; i < kept_n; i++)
            if (ranks_above(kept_sc[w], kept_id[w], kept_sc[i], kept_id[i]))
                w = i;
        return w;
    endfunction

    // advance the store by one item; queue its results when record is set
    task automatic update_top_k(input logic mode, input logic [SCORE_W-1:0] sc,
                                input logic [DOC_W-1:0] doc, input bit record);
        t_heap_result       r;
        logic [SCORE_W-1:0] srt_sc [K];
        logic [DOC_W-1:0]   srt_id [K];
        int                 w;
        int                 j;
        int                 n;
        r = '{default: '0};
        r.last = 1'b1;
        if (!mode) begin
            if (kept_n < K) begin
                kept_sc[kept_n] = sc;
                kept_id[kept_n] = doc;
                kept_n++;
            end else begin
                w = weakest_slot();
                kept_sc[w] = sc;
                kept_id[w] = doc;
            end
            if (kept_n == K) begin
                w = weakest_slot();
                if ($signed(thr_now) < $signed({1'b0, kept_sc[w]}))
                    thr_now = {1'b0, kept_sc[w]};
            end
            r.threshold = thr_now;
            r.full = (kept_n == K);
            if (record)
                queue_result(r);
        end else begin
            n = kept_n;
            for (int i = 0; i < n; i++) begin
                j = i;
                while (j > 0 && ranks_above(kept_sc[i], kept_id[i], srt_sc[j-1], srt_id[j-1])) begin
                    srt_sc[j] = srt_sc[j-1];
                    srt_id[j] = srt_id[j-1];
                    j--;
                end
                srt_sc[j] = kept_sc[i];
                srt_id[j] = kept_id[i];
            end
            kept_n = 0;
            thr_now = thr_start;
            r.threshold = thr_now;
            if (record && n == 0)
                queue_result(r);
            for (int i = 0; record && i < n; i++) begin
                r.entry_score = srt_sc[i];
                r.entry_doc = srt_id[i];
                r.entry_valid = 1'b1;
                r.last = (i == n - 1);
                queue_result(r);
            end
        end
    endtask

    task automatic send_item(input logic mode, input logic [SCORE_W-1:0] sc,
                             input logic [DOC_W-1:0] doc, input bit record);
        while (!quiet_window() && $urandom_range(99) < 22) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, doc, sc};
        s_tuser <= mode;
        do @(posedge i_clk); while (!s_tready);
        update_top_k(mode, sc, doc, record);
        n_items++;
        if (mode)
            n_drains++;
    endtask

    task automatic wait_results_done();
        s_tvalid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_start_threshold(input logic [31:0] value);
        wait_results_done();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        thr_start = value;
        n_cfg++;
    endtask

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %h, got %h", name, want, got);
            errors++;
        end
    endfunction

    // result side: checks every transaction, random back-pressure, one long hold-off
    initial begin
        t_heap_result want;
        int stall_left;
        bit stall_done;
        stall_left = 0;
        stall_done = 1'b0;
        m_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_tvalid && m_tready) begin
                results_seen++;
                if (due_results.size() == 0) begin
                    $error("unexpected result transaction %h", m_tdata);
                    errors++;
                end else begin
                    want = due_results.pop_front();
                    check_field("threshold", want.threshold, m_tdata[31:0]);
                    check_field("full_res", 32'(want.full), 32'(m_tdata[32]));
                    check_field("entry_score", 32'(want.entry_score), 32'(m_tdata[63:33]));
                    check_field("entry_doc", want.entry_doc, m_tdata[95:64]);
                    check_field("entry_valid", 32'(want.entry_valid), 32'(m_tuser[0]));
                    check_field("last", 32'(want.last), 32'(m_tlast));
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (!stall_done && results_seen >= 80) begin
                stall_done = 1'b1;
                stall_left = 400;
                m_tready <= 1'b0;
            end else begin
                m_tready <= quiet_window() || ($urandom_range(99) >= 22);
            end
        end
    end

    initial begin
        int                 phase_count;
        int                 run_len;
        bit                 narrow_sc;
        bit                 narrow_id;
        logic [SCORE_W-1:0] sc;
        logic [DOC_W-1:0]   doc;
        logic [31:0]        thr_cfg;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        n_items = 0;
        n_drains = 0;
        n_cfg = 0;
        kept_n = 0;
        thr_now = '0;
        thr_start = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // most negative start threshold; filling, ties, eviction, drains
        write_start_threshold(32'h8000_0000);
        foreach (plan[i]) begin
            send_item(plan[i].mode, plan[i].score, plan[i].doc, !plan[i].typed);
            if (plan[i].typed)
                queue_result(t_heap_result'{plan[i].want_thr, plan[i].want_full,
                                            '0, '0, 1'b0, 1'b1});
        end

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: thr_cfg = 32'h7FFF_FFFF;
                1: thr_cfg = 32'h0;
                2: thr_cfg = $urandom;
                default: thr_cfg = 32'hFFFF_0000;
            endcase
            write_start_threshold(thr_cfg);
            phase_count = 0;
            while (phase_count < PHASE_ITEMS) begin
                if ($urandom_range(99) < 85) begin
                    // fill, often past K, then drain
                    run_len = $urandom_range(1) ? $urandom_range(1, K - 1)
                                                : $urandom_range(K, 40);
                    narrow_sc = 1'($urandom_range(1));
                    narrow_id = 1'($urandom_range(1));
                    for (int n = 0; n < run_len; n++) begin
                        sc = narrow_sc ? SCORE_W'($urandom_range(0, 5)) << 16
                                       : SCORE_W'($urandom);
                        doc = narrow_id ? DOC_W'($urandom_range(0, 15)) : DOC_W'($urandom);
                        send_item(1'b0, sc, doc, 1'b1);
                    end
                    send_item(1'b1, SCORE_W'($urandom), DOC_W'($urandom), 1'b1);
                    phase_count += run_len + 1;
                end else begin
                    send_item(1'($urandom_range(1)), SCORE_W'($urandom),
                              DOC_W'($urandom), 1'b1);
                    phase_count++;
                end
            end
        end

        wait_results_done();
        if (due_results.size() != 0) begin
            $error("%0d expected results never arrived", due_results.size());
            errors++;
        end
        $display("covered %0d items (%0d drains) over %0d start-threshold settings",
                 n_items, n_drains, n_cfg);
        $display("%0d result transactions checked, %0d errors", results_seen, errors);
        if (errors == 0)
            $display("top_k_score_heap regression: pass");
        else
            $display("top_k_score_heap regression: fail");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("top_k_score_heap regression: fail");
        $finish;
    end

endmodule
